>>> sv/osq_pkg.sv
// shared types and constants for the ordered sequence store
package osq_pkg;

  localparam int POS_W = 6;
  localparam int CNT_W = 6;
  localparam int IDX_W = 5;
  localparam int OP_W  = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT     = 3'd0,
    OP_INSERT_SORTED = 3'd1,
    OP_ERASE_AT      = 3'd2,
    OP_REMOVE_ALL    = 3'd3,
    OP_GET           = 3'd4,
    OP_SET           = 3'd5,
    OP_FIND          = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_ERASE,
    ACT_WRITE
  } cell_act_t;

  typedef struct packed {
    cell_act_t          act;
    logic [POS_W-1:0]   at;
  } cell_cmd_t;

endpackage

>>> sv/osq_cell.sv
// one list entry cell: holds a word, shifts with its neighbors, compares with the key
module osq_cell #(
  parameter int IDX        = 0,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                       clk,
  input  osq_pkg::cell_cmd_t         cmd,
  input  logic [ITEM_WIDTH-1:0]      key,
  input  logic [ITEM_WIDTH-1:0]      left_value,
  input  logic [ITEM_WIDTH-1:0]      right_value,
  input  logic [osq_pkg::CNT_W-1:0]  count,
  output logic [ITEM_WIDTH-1:0]      value,
  output logic                       eq,
  output logic                       ge,
  output logic [ITEM_WIDTH-1:0]      sel_value
);

  logic                  valid;
  logic                  at_here;
  logic                  past_at;
  logic [ITEM_WIDTH-1:0] value_next;

  assign valid   = IDX < int'(count);
  assign at_here = int'(cmd.at) == IDX;
  assign past_at = IDX > int'(cmd.at);

  // flags only count for live entries
  assign eq        = valid && (value == key);
  assign ge        = valid && (value >= key);
  assign sel_value = at_here ? value : '0;

  always_comb begin
    value_next = value;
    case (cmd.act)
      osq_pkg::ACT_INSERT: begin
        if (past_at) begin
          value_next = left_value;
        end else if (at_here) begin
          value_next = key;
        end
      end
      osq_pkg::ACT_ERASE: begin
        if (past_at || at_here) begin
          value_next = right_value;
        end
      end
      osq_pkg::ACT_WRITE: begin
        if (at_here) begin
          value_next = key;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

>>> sv/osq_chain.sv
// row of entry cells with neighbor links, flag vectors and positional readout
module osq_chain #(
  parameter int DEPTH      = 32,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                       clk,
  input  osq_pkg::cell_cmd_t         cmd,
  input  logic [ITEM_WIDTH-1:0]      key,
  input  logic [osq_pkg::CNT_W-1:0]  count,
  output logic [DEPTH-1:0]           eq_flags,
  output logic [DEPTH-1:0]           ge_flags,
  output logic [ITEM_WIDTH-1:0]      read_data
);

  logic [ITEM_WIDTH-1:0] values    [DEPTH];
  logic [ITEM_WIDTH-1:0] left_v    [DEPTH];
  logic [ITEM_WIDTH-1:0] right_v   [DEPTH];
  logic [ITEM_WIDTH-1:0] sel_v     [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_v[i] = '0;
    end else begin : g_left
      assign left_v[i] = values[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v[i] = '0;
    end else begin : g_right
      assign right_v[i] = values[i+1];
    end

    osq_cell #(
      .IDX        (i),
      .ITEM_WIDTH (ITEM_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .key         (key),
      .left_value  (left_v[i]),
      .right_value (right_v[i]),
      .count       (count),
      .value       (values[i]),
      .eq          (eq_flags[i]),
      .ge          (ge_flags[i]),
      .sel_value   (sel_v[i])
    );
  end

  // at most one cell is selected, so an or of all selections is the readout
  always_comb begin
    read_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_data = read_data | sel_v[i];
    end
  end

endmodule

>>> sv/ordered_sequence_store_top.sv
// top level of the ordered sequence store: sequencer, count, config and result registers
//
// channel   direction  handshake                    payload
// request   in         start && !busy               opcode, position, item_value
// result    out        done (one cycle, no stall)   status, result_index, read_value,
//                                                   removed_count, entry_count, is_empty
// config    in         cfg_write                    cfg_data (capacity_limit)
//
// insert_at, erase_at, get, set and unused opcodes finish in the decode state after accept
// find and insert_sorted go on to an upward scan that stops at the first marked entry or at the count
// an insert_sorted on a full list fails at once in the decode state
// remove_all sweeps down from the top entry unless the list is empty, one cell position checked per cycle top down
// busy stays high from accept until the cycle done is shown; results cannot be stalled
// rst is synchronous: count clears, capacity_limit returns to 32, entries stay as they are
module ordered_sequence_store_top #(
  parameter int DEPTH      = 32,
  parameter int ITEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [5:0]  position,
  input  logic [31:0] item_value,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data,
  output logic        done,
  output logic        status,
  output logic [4:0]  result_index,
  output logic [31:0] read_value,
  output logic [5:0]  removed_count,
  output logic [5:0]  entry_count,
  output logic        is_empty
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_REMOVE
  } state_t;

  // the limit in force never exceeds the built depth nor the count width
  localparam int LIM_SAT = (DEPTH < 63) ? DEPTH : 63;

  state_t                          state, state_next;
  osq_pkg::opcode_t                op_q;
  logic [osq_pkg::POS_W-1:0]       pos_q;
  logic [ITEM_WIDTH-1:0]           key;
  logic [osq_pkg::CNT_W-1:0]       count, count_next;
  logic [osq_pkg::CNT_W-1:0]       capacity_limit;
  logic [osq_pkg::CNT_W-1:0]       limit;
  logic [osq_pkg::POS_W-1:0]       scan, scan_next;
  logic [osq_pkg::CNT_W-1:0]       removed, removed_next;
  logic [DEPTH-1:0]                marks, marks_next;
  logic [DEPTH-1:0]                scan_hot;
  logic                            mark_sel;
  logic                            full;
  logic                            accept;

  osq_pkg::cell_cmd_t              cmd;
  logic [DEPTH-1:0]                eq_flags;
  logic [DEPTH-1:0]                ge_flags;
  logic [ITEM_WIDTH-1:0]           read_data;

  // result staged for the done cycle
  logic                            fin;
  logic                            fin_fail;
  logic [osq_pkg::POS_W-1:0]       fin_idx;
  logic [ITEM_WIDTH-1:0]           fin_rd;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  assign limit = (int'(capacity_limit) > LIM_SAT) ? osq_pkg::CNT_W'(LIM_SAT) : capacity_limit;
  assign full  = count >= limit;

  // decode the scan position into a one-hot pick of the mark snapshot
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      scan_hot[k] = int'(scan) == k;
    end
  end
  assign mark_sel = |(marks & scan_hot);

  osq_chain #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_chain (
    .clk       (clk),
    .cmd       (cmd),
    .key       (key),
    .count     (count),
    .eq_flags  (eq_flags),
    .ge_flags  (ge_flags),
    .read_data (read_data)
  );

  always_comb begin
    state_next   = state;
    count_next   = count;
    scan_next    = scan;
    removed_next = removed;
    marks_next   = marks;
    cmd          = '{act: osq_pkg::ACT_HOLD, at: pos_q};
    fin          = 1'b0;
    fin_fail     = 1'b1;
    fin_idx      = '0;
    fin_rd       = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        case (op_q)
          osq_pkg::OP_INSERT_AT: begin
            fin = 1'b1;
            if (!full && pos_q <= count) begin
              cmd        = '{act: osq_pkg::ACT_INSERT, at: pos_q};
              count_next = count + 1'b1;
              fin_fail   = 1'b0;
              fin_idx    = pos_q;
            end
          end
          osq_pkg::OP_INSERT_SORTED: begin
            if (full) begin
              fin = 1'b1;
            end else begin
              marks_next = ge_flags;
              scan_next  = '0;
              state_next = S_SCAN;
            end
          end
          osq_pkg::OP_ERASE_AT: begin
            fin = 1'b1;
            if (pos_q < count) begin
              cmd        = '{act: osq_pkg::ACT_ERASE, at: pos_q};
              count_next = count - 1'b1;
              fin_fail   = 1'b0;
            end
          end
          osq_pkg::OP_REMOVE_ALL: begin
            removed_next = '0;
            if (count == '0) begin
              fin      = 1'b1;
              fin_fail = 1'b0;
            end else begin
              marks_next = eq_flags;
              scan_next  = count - 1'b1;
              state_next = S_REMOVE;
            end
          end
          osq_pkg::OP_GET: begin
            fin = 1'b1;
            if (pos_q < count) begin
              fin_fail = 1'b0;
              fin_rd   = read_data;
            end
          end
          osq_pkg::OP_SET: begin
            fin = 1'b1;
            if (pos_q < count) begin
              cmd      = '{act: osq_pkg::ACT_WRITE, at: pos_q};
              fin_fail = 1'b0;
            end
          end
          osq_pkg::OP_FIND: begin
            marks_next = eq_flags;
            scan_next  = '0;
            state_next = S_SCAN;
          end
          default: begin
            // unused opcode: no change, failure
            fin = 1'b1;
          end
        endcase
      end

      S_SCAN: begin
        // stop at the first marked entry or just past the last one
        if (mark_sel || scan == count) begin
          fin = 1'b1;
          if (op_q == osq_pkg::OP_FIND) begin
            if (mark_sel) begin
              fin_fail = 1'b0;
              fin_idx  = scan;
            end
          end else begin
            cmd        = '{act: osq_pkg::ACT_INSERT, at: scan};
            count_next = count + 1'b1;
            fin_fail   = 1'b0;
            fin_idx    = scan;
          end
        end else begin
          scan_next = scan + 1'b1;
        end
      end

      S_REMOVE: begin
        // top-down sweep, so erasing never moves an entry still to be checked
        if (mark_sel) begin
          cmd          = '{act: osq_pkg::ACT_ERASE, at: scan};
          count_next   = count - 1'b1;
          removed_next = removed + 1'b1;
        end
        if (scan == '0) begin
          fin      = 1'b1;
          fin_fail = 1'b0;
        end else begin
          scan_next = scan - 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      count          <= '0;
      capacity_limit <= osq_pkg::CAP_RESET;
      done           <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      scan    <= scan_next;
      removed <= removed_next;
      marks   <= marks_next;
      done    <= fin;

      if (cfg_write) begin
        capacity_limit <= cfg_data;
      end

      // latch the request item; key is reduced or widened to the entry width
      if (accept) begin
        op_q  <= osq_pkg::opcode_t'(opcode);
        pos_q <= position;
        key   <= ITEM_WIDTH'(item_value);
      end

      if (fin) begin
        status        <= fin_fail;
        result_index  <= fin_idx[osq_pkg::IDX_W-1:0];
        read_value    <= 32'(fin_rd);
        removed_count <= (op_q == osq_pkg::OP_REMOVE_ALL) ? removed_next : '0;
        entry_count   <= count_next;
        is_empty      <= count_next == '0;
      end
    end
  end

endmodule

>>> test/tb_ordered_sequence_store_top.sv
// testbench for the ordered sequence store: list scoreboard, request driver and result monitor
module tb_ordered_sequence_store_top;

  localparam int DEPTH          = 32;
  localparam int ITEM_WIDTH     = 32;
  // slowest item is a scan over a full list plus a sender gap
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 40;
  // the one opcode the package leaves unnamed
  localparam logic [osq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [5:0]  position = '0;
  logic [31:0] item_value = '0;
  logic        cfg_write = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        done;
  logic        status;
  logic [4:0]  result_index;
  logic [31:0] read_value;
  logic [5:0]  removed_count;
  logic [5:0]  entry_count;
  logic        is_empty;

  // one expected reply, field for field as on the result ports
  typedef struct {
    logic        status;
    logic [4:0]  result_index;
    logic [31:0] read_value;
    logic [5:0]  removed_count;
    logic [5:0]  entry_count;
    logic        is_empty;
  } reply_t;

  // mirror of the list plus the queue of replies still to come
  class list_scoreboard;
    logic [31:0] words [DEPTH];
    int unsigned fill;
    int unsigned cap;
    reply_t      pending_replies [$];
    int          errors;

    function new();
      fill   = 0;
      cap    = osq_pkg::CAP_RESET;
      errors = 0;
    endfunction

    // shift right and drop the word in, unless full or the slot is past the end
    function bit place(int unsigned at, logic [31:0] v);
      int unsigned lim;
      lim = (cap < DEPTH) ? cap : DEPTH;
      if (fill >= lim || at > fill) return 1'b0;
      for (int unsigned i = fill; i > at; i--) words[i] = words[i - 1];
      words[at] = v;
      fill++;
      return 1'b1;
    endfunction

    // advance the mirror by one request and queue the reply it must give
    function void note_request(logic [2:0] op, logic [5:0] pos, logic [31:0] v);
      reply_t      r;
      int unsigned i;
      int unsigned w;
      r.status        = 1'b1;
      r.result_index  = '0;
      r.read_value    = '0;
      r.removed_count = '0;
      case (op)
        osq_pkg::OP_INSERT_AT: if (place(pos, v)) begin
          r.status       = 1'b0;
          r.result_index = pos[4:0];
        end
        osq_pkg::OP_INSERT_SORTED: begin
          i = 0;
          while (i < fill && words[i] < v) i++;
          if (place(i, v)) begin
            r.status       = 1'b0;
            r.result_index = i[4:0];
          end
        end
        osq_pkg::OP_ERASE_AT: if (pos < fill) begin
          for (i = pos; i + 1 < fill; i++) words[i] = words[i + 1];
          fill--;
          r.status = 1'b0;
        end
        osq_pkg::OP_REMOVE_ALL: begin
          w = 0;
          for (i = 0; i < fill; i++) begin
            if (words[i] == v) begin
              r.removed_count++;
            end else begin
              words[w] = words[i];
              w++;
            end
          end
          fill     = w;
          r.status = 1'b0;
        end
        osq_pkg::OP_GET: if (pos < fill) begin
          r.read_value = words[pos];
          r.status     = 1'b0;
        end
        osq_pkg::OP_SET: if (pos < fill) begin
          words[pos] = v;
          r.status   = 1'b0;
        end
        osq_pkg::OP_FIND: begin
          for (i = 0; i < fill; i++) begin
            if (words[i] == v) begin
              r.status       = 1'b0;
              r.result_index = i[4:0];
              break;
            end
          end
        end
        default: ;
      endcase
      r.entry_count = fill[5:0];
      r.is_empty    = (fill == 0);
      pending_replies.push_back(r);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic st, logic [4:0] idx, logic [31:0] rd,
                               logic [5:0] rem, logic [5:0] cnt, logic emp);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      compare("status", want.status, st);
      compare("result_index", want.result_index, idx);
      compare("read_value", want.read_value, rd);
      compare("removed_count", want.removed_count, rem);
      compare("entry_count", want.entry_count, cnt);
      compare("is_empty", want.is_empty, emp);
    endfunction
  endclass

  list_scoreboard sb;
  int             quiet_cycles = 0;

  ordered_sequence_store_top #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .position      (position),
    .item_value    (item_value),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .result_index  (result_index),
    .read_value    (read_value),
    .removed_count (removed_count),
    .entry_count   (entry_count),
    .is_empty      (is_empty)
  );

  // period of 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor and watchdog; samples the values that held before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result(status, result_index, read_value, removed_count,
                        entry_count, is_empty);
      end
      // any handshake or register write counts as progress
      if (done || (start && !busy) || cfg_write) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // hold one item on the request ports until the block takes it;
  // start is left high so a back-to-back item needs no fresh toggle of start
  task automatic send_item(logic [2:0] op, logic [5:0] pos, logic [31:0] v);
    start      <= 1'b1;
    opcode     <= op;
    position   <= pos;
    item_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, pos, v);
  endtask

  // stop sending and wait until every reply is in and the block is idle
  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0 || busy) @(posedge clk);
  endtask

  // capacity register only changes while the block is idle
  task automatic write_limit(logic [5:0] v);
    drain_replies();
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.cap = v;
  endtask

  // mix of words already in the list, a pool of corner values, and full random
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3 && sb.fill > 0) return sb.words[$urandom_range(0, sb.fill - 1)];
    if (r < 7) begin
      case ($urandom_range(0, 7))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'h0000_0007;
        3: return 32'h7fff_ffff;
        4: return 32'h8000_0000;
        5: return 32'hdead_beef;
        6: return 32'hffff_fffe;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // random items in bursts; fill_bias is the percentage of inserts
  task automatic run_phase(int n, int fill_bias);
    int         burst;
    int         gap;
    logic [2:0] op;
    logic [5:0] pos;
    burst = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < fill_bias) begin
        op = $urandom_range(0, 1) ? osq_pkg::OP_INSERT_SORTED : osq_pkg::OP_INSERT_AT;
      end else begin
        op = 3'($urandom_range(int'(osq_pkg::OP_ERASE_AT), int'(OP_UNUSED)));
        // unused opcode only now and then
        if (op == OP_UNUSED && $urandom_range(0, 3) != 0) op = osq_pkg::OP_FIND;
      end
      // mostly positions around the live range, sometimes anywhere
      if ($urandom_range(0, 9) == 0) pos = 6'($urandom_range(0, 63));
      else pos = 6'($urandom_range(0, sb.fill));
      send_item(op, pos, pick_value());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) begin
          // let the pipeline run dry before the next burst
          drain_replies();
        end else begin
          gap = $urandom_range(0, 6);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: reads, erase and set fail, remove_all succeeds with nothing
    send_item(osq_pkg::OP_GET, 6'd0, 32'h0);
    send_item(osq_pkg::OP_ERASE_AT, 6'd0, 32'h0);
    send_item(osq_pkg::OP_SET, 6'd0, 32'h1);
    send_item(osq_pkg::OP_FIND, 6'd0, 32'h0);
    send_item(osq_pkg::OP_REMOVE_ALL, 6'd0, 32'h0);
    send_item(OP_UNUSED, 6'd0, 32'h0);

    // insert past the end fails, at the end appends
    send_item(osq_pkg::OP_INSERT_AT, 6'd1, 32'h5);
    send_item(osq_pkg::OP_INSERT_AT, 6'd0, 32'h0000_0000);
    send_item(osq_pkg::OP_INSERT_AT, 6'd1, 32'hffff_ffff);
    // sorted insert: middle, before an equal word, at the front
    send_item(osq_pkg::OP_INSERT_SORTED, 6'd0, 32'h8000_0000);
    send_item(osq_pkg::OP_INSERT_SORTED, 6'd0, 32'hffff_ffff);
    send_item(osq_pkg::OP_INSERT_SORTED, 6'd0, 32'h0000_0000);
    send_item(osq_pkg::OP_INSERT_AT, 6'd63, 32'h1);

    // list is now 0, 0, 8000_0000, ffff_ffff, ffff_ffff
    send_item(osq_pkg::OP_FIND, 6'd0, 32'hffff_ffff);
    send_item(osq_pkg::OP_FIND, 6'd0, 32'h0001_2345);
    send_item(osq_pkg::OP_GET, 6'd4, 32'h0);
    send_item(osq_pkg::OP_GET, 6'd5, 32'h0);
    send_item(osq_pkg::OP_SET, 6'd2, 32'ha5a5_a5a5);
    send_item(osq_pkg::OP_SET, 6'd63, 32'h0);
    send_item(osq_pkg::OP_REMOVE_ALL, 6'd0, 32'hffff_ffff);
    send_item(osq_pkg::OP_ERASE_AT, 6'd3, 32'h0);
    send_item(osq_pkg::OP_ERASE_AT, 6'd0, 32'h0);
    send_item(OP_UNUSED, 6'd63, 32'hffff_ffff);

    // limit below the current count: inserts fail, the rest still works
    write_limit(6'd1);
    send_item(osq_pkg::OP_INSERT_AT, 6'd0, 32'h3);
    send_item(osq_pkg::OP_INSERT_SORTED, 6'd0, 32'h3);
    send_item(osq_pkg::OP_GET, 6'd1, 32'h0);
    // zero limit: every insert fails
    write_limit(6'd0);
    send_item(osq_pkg::OP_INSERT_SORTED, 6'd0, 32'h0);
    send_item(osq_pkg::OP_ERASE_AT, 6'd0, 32'h0);

    // random phases over a spread of limits, extremes included
    write_limit(6'd32);
    run_phase(50, 60);
    // above the built depth, fill hard so the list reaches full depth
    write_limit(6'd63);
    run_phase(70, 85);
    write_limit(6'd4);
    run_phase(50, 50);
    write_limit(6'd1);
    run_phase(40, 50);
    write_limit(6'd0);
    run_phase(40, 40);
    write_limit(6'($urandom_range(2, 31)));
    run_phase(50, 55);
    write_limit(6'd32);
    run_phase(50, 25);
    write_limit(6'd63);
    run_phase(50, 70);

    // wait out the last replies, then a margin for any stray strobe
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
